// ===== rtl/bthalloc_pkg.sv =====
// shared types, codes and constants for the boundary-tag heap allocator
// no dependencies; imported by every module of the block

package bthalloc_pkg;

    localparam int HEAP_WORDS_DEF = 8192;
    localparam int KIND_W         = 2;
    localparam int REQ_W          = 16;
    localparam int PADDR_W        = 15;
    localparam int STATUS_W       = 2;
    localparam int CHUNK_W        = 16;
    localparam int CHUNK_RESET    = 4096;
    localparam int APB_AW         = 3;

    typedef logic [31:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_REJECT    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CALL_INIT  = 2'd0,
        CALL_ALLOC = 2'd1,
        CALL_FREE  = 2'd2
    } caller_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISPATCH,
        ST_INIT0, ST_INIT1, ST_INIT2, ST_INIT3,
        ST_GROW0, ST_GROW1, ST_GROW2, ST_GROW3,
        ST_MRG0, ST_MRG1, ST_MRG2, ST_MRG3, ST_MRG4, ST_MRG5, ST_MRG6, ST_MRG7,
        ST_MRET,
        ST_SCAN0, ST_SCAN1,
        ST_CARVE0, ST_CARVE1, ST_CARVE2, ST_CARVE3, ST_CARVE4, ST_CARVE5,
        ST_FREE0, ST_FREE1, ST_FREE2, ST_FREE3,
        ST_DONE
    } state_t;

    // one heap access per cycle, byte address
    typedef struct packed {
        logic  rd;
        logic  wr;
        word_t addr;
        word_t wdata;
    } mem_req_t;

    localparam word_t DWORD_B   = 32'd8;
    localparam word_t WORD_B    = 32'd4;
    localparam word_t MIN_BLOCK = 32'd16;
    localparam word_t PRO_TAG   = 32'd9;
    localparam word_t EPI_TAG   = 32'd1;
    localparam word_t SIZE_MASK = 32'hFFFF_FFF8;

endpackage

// ===== rtl/bthalloc_mem.sv =====
// heap word memory, one access per cycle, registered read data
// depends on bthalloc_pkg; addresses outside the memory read 0 and drop writes

module bthalloc_mem
    import bthalloc_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output word_t    rdata
);

    localparam int IDX_W = $clog2(HEAP_WORDS);

    word_t            mem [HEAP_WORDS];
    word_t            q_reg;
    logic             ok_reg;
    logic             in_range;
    logic [IDX_W-1:0] idx;

    assign in_range = (req.addr >> 2) < 32'(HEAP_WORDS);
    assign idx      = req.addr[IDX_W+1:2];

    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd && in_range)
        begin
            q_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= req.rd && in_range;
        end
    end

    assign rdata = ok_reg ? q_reg : '0;

endmodule

// ===== rtl/bthalloc_ctrl.sv =====
// sequencer for init, allocate and free; walks block tags in the heap memory
// depends on bthalloc_pkg; drives bthalloc_mem through a mem_req_t

module bthalloc_ctrl
    import bthalloc_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  in_kind,
    input  logic [REQ_W-1:0]   in_req,
    input  logic [PADDR_W-1:0] in_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PADDR_W-1:0] out_payload,
    output logic [STATUS_W-1:0] out_status,
    input  logic [CHUNK_W-1:0] chunk,
    output mem_req_t           mem_req,
    input  word_t              mem_rdata
);

    localparam word_t CAP = 32'(HEAP_WORDS * 4);

    state_t  state_reg, state_next;
    caller_t caller_reg, caller_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [PADDR_W-1:0] addr_reg, addr_next;
    word_t   brk_reg, brk_next;
    logic    init_reg, init_next;
    word_t   need_reg, need_next;
    word_t   bp_reg, bp_next;
    word_t   sz_reg, sz_next;
    word_t   psz_reg, psz_next;
    word_t   pb_reg, pb_next;
    word_t   nb_reg, nb_next;
    logic    pused_reg, pused_next;
    word_t   msize_reg, msize_next;
    word_t   hdr_reg, hdr_next;
    word_t   fbase_reg, fbase_next;
    word_t   ret_reg, ret_next;
    word_t   gbytes_reg, gbytes_next;
    word_t   tsz_reg, tsz_next;
    logic    split_reg, split_next;
    logic [PADDR_W-1:0] res_pay_reg, res_pay_next;
    status_t res_st_reg, res_st_next;
    logic    ov_reg, ov_next;
    logic [PADDR_W-1:0] opay_reg, opay_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;

    word_t rsize;
    logic  rused;
    word_t gwords, graw, gsize;
    logic  grow_fail;
    word_t need_calc;
    word_t chunk_w;
    logic  alloc_ok, free_ok0, free_ok1;
    logic  scan_end, scan_hit;
    logic  accept, out_free;

    assign rsize     = mem_rdata & SIZE_MASK;
    assign rused     = mem_rdata[0];
    assign chunk_w   = 32'(chunk);
    assign gwords    = gbytes_reg >> 2;
    assign graw      = (gwords + {31'd0, gwords[0]}) << 2;
    assign gsize     = (graw == '0) ? DWORD_B : graw;
    assign grow_fail = (brk_reg > CAP) || (gsize > CAP - brk_reg);
    assign need_calc = (32'(req_reg) <= DWORD_B) ? MIN_BLOCK
                     : ((32'(req_reg) + 32'd15) & SIZE_MASK);
    assign alloc_ok  = init_reg && (req_reg != '0);
    assign free_ok0  = init_reg && (addr_reg[2:0] == 3'd0)
                     && (32'(addr_reg) >= MIN_BLOCK) && (32'(addr_reg) < brk_reg);
    assign free_ok1  = rused && (rsize >= DWORD_B) && (rsize <= brk_reg - 32'(addr_reg));
    assign scan_end  = (bp_reg - WORD_B) >= brk_reg;
    assign scan_hit  = !rused && (rsize >= need_reg);
    assign accept    = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ov_reg;
    assign out_payload = opay_reg;
    assign out_status  = ost_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (kind_reg)
                    KIND_INIT:  state_next = ST_INIT0;
                    KIND_ALLOC: state_next = alloc_ok ? ST_SCAN0 : ST_DONE;
                    KIND_FREE:  state_next = free_ok0 ? ST_FREE0 : ST_DONE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_INIT0:  state_next = ST_INIT1;
            ST_INIT1:  state_next = ST_INIT2;
            ST_INIT2:  state_next = ST_INIT3;
            ST_INIT3:  state_next = ST_GROW0;
            ST_GROW0:  state_next = grow_fail ? ST_DONE : ST_GROW1;
            ST_GROW1:  state_next = ST_GROW2;
            ST_GROW2:  state_next = ST_GROW3;
            ST_GROW3:  state_next = ST_MRG0;
            ST_MRG0:   state_next = ST_MRG1;
            ST_MRG1:   state_next = ST_MRG2;
            ST_MRG2:   state_next = ST_MRG3;
            ST_MRG3:   state_next = ST_MRG4;
            ST_MRG4:   state_next = (pused_reg && rused) ? ST_MRET : ST_MRG5;
            ST_MRG5:   state_next = ST_MRG6;
            ST_MRG6:   state_next = ST_MRG7;
            ST_MRG7:   state_next = ST_MRET;
            ST_MRET:
            begin
                if (caller_reg == CALL_ALLOC && ret_reg != '0)
                begin
                    state_next = ST_CARVE0;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN0:  state_next = scan_end ? ST_GROW0 : ST_SCAN1;
            ST_SCAN1:
            begin
                if (rsize == '0)
                begin
                    state_next = ST_GROW0;
                end
                else if (scan_hit)
                begin
                    state_next = ST_CARVE0;
                end
                else
                begin
                    state_next = ST_SCAN0;
                end
            end
            ST_CARVE0: state_next = ST_CARVE1;
            ST_CARVE1: state_next = ST_CARVE2;
            ST_CARVE2: state_next = ST_CARVE3;
            ST_CARVE3: state_next = split_reg ? ST_CARVE4 : ST_DONE;
            ST_CARVE4: state_next = ST_CARVE5;
            ST_CARVE5: state_next = ST_DONE;
            ST_FREE0:  state_next = ST_FREE1;
            ST_FREE1:  state_next = free_ok1 ? ST_FREE2 : ST_DONE;
            ST_FREE2:  state_next = ST_FREE3;
            ST_FREE3:  state_next = ST_MRG0;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        mem_req      = '0;
        caller_next  = caller_reg;
        kind_next    = kind_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        brk_next     = brk_reg;
        init_next    = init_reg;
        need_next    = need_reg;
        bp_next      = bp_reg;
        sz_next      = sz_reg;
        psz_next     = psz_reg;
        pb_next      = pb_reg;
        nb_next      = nb_reg;
        pused_next   = pused_reg;
        msize_next   = msize_reg;
        hdr_next     = hdr_reg;
        fbase_next   = fbase_reg;
        ret_next     = ret_reg;
        gbytes_next  = gbytes_reg;
        tsz_next     = tsz_reg;
        split_next   = split_reg;
        res_pay_next = res_pay_reg;
        res_st_next  = res_st_reg;
        ov_next      = ov_reg && !out_ready;
        opay_next    = opay_reg;
        ost_next     = ost_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_kind;
                    req_next  = in_req;
                    addr_next = in_addr;
                end
            end
            ST_DISPATCH:
            begin
                res_pay_next = '0;
                res_st_next  = STATUS_REJECT;
                need_next    = need_calc;
                bp_next      = DWORD_B;
                caller_next  = CALL_ALLOC;
                if (kind_reg == KIND_INIT)
                begin
                    caller_next = CALL_INIT;
                end
                else if (kind_reg == KIND_FREE)
                begin
                    caller_next = CALL_FREE;
                end
            end
            ST_INIT0:
            begin
                brk_next      = '0;
                mem_req.wr    = 1'b1;
                mem_req.addr  = 32'd0;
                mem_req.wdata = '0;
            end
            ST_INIT1:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = 32'd4;
                mem_req.wdata = PRO_TAG;
            end
            ST_INIT2:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = 32'd8;
                mem_req.wdata = PRO_TAG;
            end
            ST_INIT3:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = 32'd12;
                mem_req.wdata = EPI_TAG;
                brk_next      = MIN_BLOCK;
                init_next     = 1'b1;
                gbytes_next   = chunk_w;
            end
            ST_GROW0:
            begin
                if (grow_fail)
                begin
                    res_st_next = STATUS_EXHAUSTED;
                end
                else
                begin
                    bp_next  = brk_reg;
                    brk_next = brk_reg + gsize;
                    sz_next  = gsize;
                end
            end
            ST_GROW1:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg - WORD_B;
                mem_req.wdata = sz_reg;
            end
            ST_GROW2:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + sz_reg - DWORD_B;
                mem_req.wdata = sz_reg;
            end
            ST_GROW3:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + sz_reg - WORD_B;
                mem_req.wdata = EPI_TAG;
            end
            ST_MRG0:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = bp_reg - DWORD_B;
            end
            ST_MRG1:
            begin
                pb_next      = bp_reg - rsize;
                mem_req.rd   = 1'b1;
                mem_req.addr = bp_reg - WORD_B;
            end
            ST_MRG2:
            begin
                sz_next      = rsize;
                nb_next      = bp_reg + rsize;
                mem_req.rd   = 1'b1;
                mem_req.addr = pb_reg - WORD_B;
            end
            ST_MRG3:
            begin
                pused_next   = rused;
                psz_next     = rsize;
                mem_req.rd   = 1'b1;
                mem_req.addr = nb_reg - WORD_B;
            end
            ST_MRG4:
            begin
                // four neighbor cases; rdata holds the next block's header
                ret_next = bp_reg;
                if (!pused_reg && rused)
                begin
                    msize_next = sz_reg + psz_reg;
                    hdr_next   = pb_reg - WORD_B;
                    fbase_next = bp_reg;
                    ret_next   = pb_reg;
                end
                else if (pused_reg && !rused)
                begin
                    msize_next = sz_reg + rsize;
                    hdr_next   = bp_reg - WORD_B;
                    fbase_next = bp_reg;
                end
                else if (!pused_reg && !rused)
                begin
                    msize_next = sz_reg + psz_reg + rsize;
                    hdr_next   = pb_reg - WORD_B;
                    fbase_next = nb_reg;
                    ret_next   = pb_reg;
                end
            end
            ST_MRG5:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = hdr_reg;
                mem_req.wdata = msize_reg;
            end
            ST_MRG6:
            begin
                // footer place follows the header as it reads after the write
                mem_req.rd   = 1'b1;
                mem_req.addr = fbase_reg - WORD_B;
            end
            ST_MRG7:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = fbase_reg + rsize - DWORD_B;
                mem_req.wdata = msize_reg;
            end
            ST_MRET:
            begin
                case (caller_reg)
                    CALL_INIT:
                        res_st_next = (ret_reg != '0) ? STATUS_OK : STATUS_EXHAUSTED;
                    CALL_ALLOC:
                    begin
                        bp_next = ret_reg;
                        if (ret_reg == '0)
                        begin
                            res_st_next = STATUS_EXHAUSTED;
                        end
                    end
                    default:
                        res_st_next = STATUS_OK;
                endcase
            end
            ST_SCAN0:
            begin
                if (scan_end)
                begin
                    gbytes_next = (need_reg > chunk_w) ? need_reg : chunk_w;
                end
                else
                begin
                    mem_req.rd   = 1'b1;
                    mem_req.addr = bp_reg - WORD_B;
                end
            end
            ST_SCAN1:
            begin
                if (rsize == '0 || scan_hit)
                begin
                    gbytes_next = (need_reg > chunk_w) ? need_reg : chunk_w;
                end
                else
                begin
                    bp_next = bp_reg + rsize;
                end
            end
            ST_CARVE0:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = bp_reg - WORD_B;
            end
            ST_CARVE1:
            begin
                sz_next    = rsize;
                split_next = (rsize - need_reg) >= MIN_BLOCK;
                tsz_next   = ((rsize - need_reg) >= MIN_BLOCK) ? need_reg : rsize;
            end
            ST_CARVE2:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg - WORD_B;
                mem_req.wdata = tsz_reg | EPI_TAG;
            end
            ST_CARVE3:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + tsz_reg - DWORD_B;
                mem_req.wdata = tsz_reg | EPI_TAG;
                res_pay_next  = bp_reg[PADDR_W-1:0];
                res_st_next   = STATUS_OK;
            end
            ST_CARVE4:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + need_reg - WORD_B;
                mem_req.wdata = sz_reg - need_reg;
            end
            ST_CARVE5:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + sz_reg - DWORD_B;
                mem_req.wdata = sz_reg - need_reg;
            end
            ST_FREE0:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = 32'(addr_reg) - WORD_B;
            end
            ST_FREE1:
            begin
                sz_next = rsize;
                bp_next = 32'(addr_reg);
            end
            ST_FREE2:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg - WORD_B;
                mem_req.wdata = sz_reg;
            end
            ST_FREE3:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = bp_reg + sz_reg - DWORD_B;
                mem_req.wdata = sz_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    opay_next = res_pay_reg;
                    ost_next  = res_st_reg;
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            brk_reg   <= '0;
            init_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        caller_reg  <= caller_next;
        kind_reg    <= kind_next;
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        need_reg    <= need_next;
        bp_reg      <= bp_next;
        sz_reg      <= sz_next;
        psz_reg     <= psz_next;
        pb_reg      <= pb_next;
        nb_reg      <= nb_next;
        pused_reg   <= pused_next;
        msize_reg   <= msize_next;
        hdr_reg     <= hdr_next;
        fbase_reg   <= fbase_next;
        ret_reg     <= ret_next;
        gbytes_reg  <= gbytes_next;
        tsz_reg     <= tsz_next;
        split_reg   <= split_next;
        res_pay_reg <= res_pay_next;
        res_st_reg  <= res_st_next;
        opay_reg    <= opay_next;
        ost_reg     <= ost_next;
    end

`ifndef SYNTHESIS
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd && mem_req.wr))
        else $error("read and write issued together");

    a_brk_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        brk_reg[2:0] == 3'd0)
        else $error("heap break not double-word aligned");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DISPATCH)
        else $error("accepted word not dispatched");

    a_scan_reads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN1 |-> $past(mem_req.rd))
        else $error("header check without a read");
`endif

endmodule

// ===== rtl/boundary_tag_heap_allocator_top.sv =====
// from accept to m_tvalid: init writes the prologue and epilogue, then grows the heap by the first chunk
// alloc walks block headers, splits a block that leaves a large enough remainder, and grows the heap when none fits
// free rewrites the block's tags and merges with a free neighbor; rejected words skip the heap updates
// one word in flight: a new word is taken only after the last result is handed to m_tvalid; the single heap
// memory port and the heap layout set the pace
// reset: asynchronous active-low, clears break, init flag and chunk size (4096); heap kept
module boundary_tag_heap_allocator_top
    import bthalloc_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // req_bytes[15:0], block_addr[30:16]
    input  logic [1:0]        s_tuser,   // kind[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // payload_addr[14:0], status[16:15]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CHUNK_W-1:0]  chunk_reg;
    mem_req_t            mem_req;
    word_t               mem_rdata;
    logic [PADDR_W-1:0]  out_payload;
    logic [STATUS_W-1:0] out_status;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == '0);
    assign prdata  = reg_sel ? {16'd0, chunk_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_W'(CHUNK_RESET);
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            chunk_reg <= pwdata[CHUNK_W-1:0];
        end
    end

    bthalloc_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_req      (s_tdata[15:0]),
        .in_addr     (s_tdata[30:16]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_payload (out_payload),
        .out_status  (out_status),
        .chunk       (chunk_reg),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    bthalloc_mem #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign m_tdata = {7'd0, out_status, out_payload};

endmodule
